@@ design/slpe_pkg.sv @@
package slpe_pkg;

    // Field widths of the request and response transactions
    localparam int ACTION_W = 2;
    localparam int KEY_W    = 64;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    // Default sizing
    localparam int POOL_SLOTS_DEF = 16;
    localparam int KEY_BITS_DEF   = 64;

    // Request actions; the unused code behaves as a lookup
    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_SPARE  = 2'd3
    } action_t;

    // Response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_ABSENT = 2'd3
    } status_t;

endpackage

@@ design/slpe_req_if.sv @@
interface slpe_req_if;
    logic                          valid;
    logic                          ready;
    logic [slpe_pkg::ACTION_W-1:0] action;
    logic                          list_select;
    logic [slpe_pkg::KEY_W-1:0]    key;

    modport source (output valid, output action, output list_select, output key, input ready);
    modport sink (input valid, input action, input list_select, input key, output ready);
endinterface

@@ design/slpe_rsp_if.sv @@
interface slpe_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [slpe_pkg::STATUS_W-1:0] status;
    logic [slpe_pkg::SLOT_W-1:0]   slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink (input valid, input status, input slot, output ready);
endinterface

@@ design/slpe_ram.sv @@
module slpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/sorted_list_pool_engine.sv @@
// Sorted list pool engine: two ascending sorted singly linked lists (A and B)
// share one pool of POOL_SLOTS node slots; unused slots sit on a free list.
// Request channel (req): action (insert, delete, lookup), list_select, key.
// Only the low KEY_BITS bits of the key count, compared as unsigned values.
// Response channel (rsp): one transaction per request with status and slot.
// Insert links the key ahead of the first key not smaller; delete unlinks
// the first equal key; lookup returns the slot of the first equal key.
// Each compared node is read from the link and key memories (S_READ), then
// compared (S_CMP); a walk off the list end stops in S_READ. Insert relinks
// in S_INS_RD, S_INS_WR1 and S_INS_WR2, delete in S_DEL_WR1 and S_DEL_WR2.
// S_IDLE captures requests, S_DONE loads responses. A request that fails at
// once (pool full, list empty) goes from S_IDLE to S_DONE. The walk through
// the link memory sets the rate; one request is in flight at a time.
// After reset the engine runs a link setup pass that chains every slot onto
// the free list; req.ready stays low during it.
// The response sits in an output register: a new request is accepted while
// it waits, and a finished request holds in its final state while rsp is
// stalled.
module sorted_list_pool_engine #(
    parameter int POOL_SLOTS = slpe_pkg::POOL_SLOTS_DEF,
    parameter int KEY_BITS   = slpe_pkg::KEY_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    slpe_req_if.sink    req,
    slpe_rsp_if.source  rsp
);

    localparam int IDX_W = $clog2(POOL_SLOTS);
    localparam int PTR_W = $clog2(POOL_SLOTS + 1);
    localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_SLOTS);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CMP,
        S_INS_RD,
        S_INS_WR1,
        S_INS_WR2,
        S_DEL_WR1,
        S_DEL_WR2,
        S_DONE
    } state_t;

    state_t                        state_reg, state_next;
    logic [IDX_W-1:0]              init_idx_reg, init_idx_next;
    logic [PTR_W-1:0]              heads_reg [2];
    logic [PTR_W-1:0]              heads_next [2];
    logic [PTR_W-1:0]              free_head_reg, free_head_next;
    logic [PTR_W-1:0]              cur_reg, cur_next;
    logic [PTR_W-1:0]              prev_reg, prev_next;
    logic [PTR_W-1:0]              after_reg, after_next;
    logic [PTR_W-1:0]              fresh_reg, fresh_next;
    logic [PTR_W-1:0]              steps_reg, steps_next;
    logic [PTR_W-1:0]              res_slot_reg, res_slot_next;
    slpe_pkg::status_t             res_status_reg, res_status_next;
    slpe_pkg::action_t             action_reg, action_next;
    logic                          sel_reg, sel_next;
    logic [KEY_BITS-1:0]           key_reg, key_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    slpe_pkg::status_t             rsp_status_reg, rsp_status_next;
    logic [slpe_pkg::SLOT_W-1:0]   rsp_slot_reg, rsp_slot_next;

    // Memory ports
    logic                link_we;
    logic [IDX_W-1:0]    link_waddr;
    logic [PTR_W-1:0]    link_wdata;
    logic [PTR_W-1:0]    link_rdata;
    logic                key_we;
    logic [KEY_BITS-1:0] key_rdata;
    logic [IDX_W-1:0]    raddr;
    logic [PTR_W-1:0]    link_clamped;
    logic [PTR_W+slpe_pkg::SLOT_W-1:0] slot_ext;

    slpe_ram #(
        .WIDTH (PTR_W),
        .DEPTH (POOL_SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (raddr),
        .rdata (link_rdata)
    );

    slpe_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (POOL_SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (fresh_reg[IDX_W-1:0]),
        .wdata (key_reg),
        .raddr (raddr),
        .rdata (key_rdata)
    );

    // Treat any link outside the pool as null
    assign link_clamped = (link_rdata >= NIL) ? NIL : link_rdata;

    // Read the node being walked, or the free head during insert
    assign raddr = (state_reg == S_INS_RD) ? fresh_reg[IDX_W-1:0] : cur_reg[IDX_W-1:0];

    // Keep the low slot bits of the result slot
    assign slot_ext = {{slpe_pkg::SLOT_W{1'b0}}, res_slot_reg};

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = rsp_valid_reg;
    assign rsp.status = rsp_status_reg;
    assign rsp.slot   = rsp_slot_reg;

    // Memory write selection
    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = cur_reg[IDX_W-1:0];
        link_wdata = NIL;
        key_we     = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                link_we    = 1'b1;
                link_waddr = init_idx_reg;
                link_wdata = PTR_W'(init_idx_reg) + PTR_W'(1);
            end
            S_INS_WR1:
            begin
                link_we    = 1'b1;
                link_waddr = fresh_reg[IDX_W-1:0];
                link_wdata = cur_reg;
                key_we     = 1'b1;
            end
            S_INS_WR2:
            begin
                link_we    = (prev_reg != NIL);
                link_waddr = prev_reg[IDX_W-1:0];
                link_wdata = fresh_reg;
            end
            S_DEL_WR1:
            begin
                link_we    = (prev_reg != NIL);
                link_waddr = prev_reg[IDX_W-1:0];
                link_wdata = after_reg;
            end
            S_DEL_WR2:
            begin
                link_we    = 1'b1;
                link_waddr = cur_reg[IDX_W-1:0];
                link_wdata = free_head_reg;
            end
            default:
            begin
                link_we = 1'b0;
            end
        endcase
    end

    // Next state and register values
    always_comb
    begin
        state_next      = state_reg;
        init_idx_next   = init_idx_reg;
        heads_next      = heads_reg;
        free_head_next  = free_head_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        after_next      = after_reg;
        fresh_next      = fresh_reg;
        steps_next      = steps_reg;
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;
        action_next     = action_reg;
        sel_next        = sel_reg;
        key_next        = key_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_slot_next   = rsp_slot_reg;

        // Drop the response once it is taken
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                init_idx_next = init_idx_reg + IDX_W'(1);
                if (init_idx_reg == IDX_W'(POOL_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    action_next = slpe_pkg::action_t'(req.action);
                    sel_next    = req.list_select;
                    key_next    = req.key[KEY_BITS-1:0];
                    cur_next    = heads_reg[req.list_select];
                    prev_next   = NIL;
                    steps_next  = '0;
                    fresh_next  = free_head_reg;
                    if (slpe_pkg::action_t'(req.action) == slpe_pkg::ACT_INSERT)
                    begin
                        if (free_head_reg == NIL)
                        begin
                            res_status_next = slpe_pkg::ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                    else if (heads_reg[req.list_select] == NIL)
                    begin
                        res_status_next = slpe_pkg::ST_EMPTY;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                // Stop at the list end or at the walk bound; else issue the read
                if (cur_reg == NIL || steps_reg == NIL)
                begin
                    if (action_reg == slpe_pkg::ACT_INSERT)
                    begin
                        cur_next   = NIL;
                        state_next = S_INS_RD;
                    end
                    else
                    begin
                        res_status_next = slpe_pkg::ST_ABSENT;
                        state_next      = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (action_reg == slpe_pkg::ACT_INSERT)
                begin
                    if (key_rdata < key_reg)
                    begin
                        prev_next  = cur_reg;
                        cur_next   = link_clamped;
                        steps_next = steps_reg + PTR_W'(1);
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_INS_RD;
                    end
                end
                else if (key_rdata != key_reg)
                begin
                    prev_next  = cur_reg;
                    cur_next   = link_clamped;
                    steps_next = steps_reg + PTR_W'(1);
                    state_next = S_READ;
                end
                else if (action_reg == slpe_pkg::ACT_DELETE)
                begin
                    after_next = link_clamped;
                    state_next = S_DEL_WR1;
                end
                else
                begin
                    res_status_next = slpe_pkg::ST_OK;
                    res_slot_next   = cur_reg;
                    state_next      = S_DONE;
                end
            end
            S_INS_RD:
            begin
                state_next = S_INS_WR1;
            end
            S_INS_WR1:
            begin
                // Pop the free list; key and forward link are written now
                free_head_next = link_clamped;
                state_next     = S_INS_WR2;
            end
            S_INS_WR2:
            begin
                if (prev_reg == NIL)
                begin
                    heads_next[sel_reg] = fresh_reg;
                end
                res_status_next = slpe_pkg::ST_OK;
                res_slot_next   = fresh_reg;
                state_next      = S_DONE;
            end
            S_DEL_WR1:
            begin
                if (prev_reg == NIL)
                begin
                    heads_next[sel_reg] = after_reg;
                end
                state_next = S_DEL_WR2;
            end
            S_DEL_WR2:
            begin
                // Push the freed slot onto the free list
                free_head_next  = cur_reg;
                res_status_next = slpe_pkg::ST_OK;
                res_slot_next   = cur_reg;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_slot_next   = (res_status_reg == slpe_pkg::ST_OK) ?
                                      slot_ext[slpe_pkg::SLOT_W-1:0] : '0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            init_idx_reg   <= '0;
            heads_reg[0]   <= NIL;
            heads_reg[1]   <= NIL;
            free_head_reg  <= '0;
            cur_reg        <= NIL;
            prev_reg       <= NIL;
            after_reg      <= NIL;
            fresh_reg      <= '0;
            steps_reg      <= '0;
            res_slot_reg   <= '0;
            res_status_reg <= slpe_pkg::ST_OK;
            action_reg     <= slpe_pkg::ACT_INSERT;
            sel_reg        <= 1'b0;
            key_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= slpe_pkg::ST_OK;
            rsp_slot_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            init_idx_reg   <= init_idx_next;
            heads_reg      <= heads_next;
            free_head_reg  <= free_head_next;
            cur_reg        <= cur_next;
            prev_reg       <= prev_next;
            after_reg      <= after_next;
            fresh_reg      <= fresh_next;
            steps_reg      <= steps_next;
            res_slot_reg   <= res_slot_next;
            res_status_reg <= res_status_next;
            action_reg     <= action_next;
            sel_reg        <= sel_next;
            key_reg        <= key_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_status_reg <= rsp_status_next;
            rsp_slot_reg   <= rsp_slot_next;
        end
    end

endmodule
